FILE: src/tlem_pkg.sv
`timescale 1ns / 1ps
package tlem_pkg;

  localparam int COORD_WIDTH   = 32;
  localparam int FRAC_BITS     = 24;
  localparam int MASS_WIDTH    = 25;
  localparam int MASS_FRAC     = 24;
  localparam int POS_WIDTH     = 64;
  localparam int HALF_WIDTH    = POS_WIDTH / 2;
  localparam int LANE_WIDTH    = (COORD_WIDTH < HALF_WIDTH) ? COORD_WIDTH : HALF_WIDTH;
  localparam int NUM_LENSES    = 3;
  localparam int CFG_IDX_WIDTH = 3;

  localparam int OFF_WIDTH     = COORD_WIDTH + 1;
  localparam int MAG_WIDTH     = COORD_WIDTH;
  localparam int SQ_WIDTH      = 2 * MAG_WIDTH;
  localparam int DEN_RAW_WIDTH = SQ_WIDTH + 1;
  localparam int NUM_SHIFT     = (2 * FRAC_BITS >= MASS_FRAC) ? 2 * FRAC_BITS - MASS_FRAC : 0;
  localparam int DEN_SHIFT     = (2 * FRAC_BITS >= MASS_FRAC) ? 0 : MASS_FRAC - 2 * FRAC_BITS;
  localparam int PROD_WIDTH    = MASS_WIDTH + MAG_WIDTH;
  localparam int NUM_WIDTH     = PROD_WIDTH + NUM_SHIFT;
  localparam int DEN_WIDTH     = DEN_RAW_WIDTH + DEN_SHIFT;
  localparam int QUO_WIDTH     = COORD_WIDTH + 2;
  localparam int HEAD_WIDTH    = NUM_WIDTH - QUO_WIDTH;
  localparam int CMP_WIDTH     = (HEAD_WIDTH > DEN_WIDTH) ? HEAD_WIDTH : DEN_WIDTH;
  localparam int TERM_WIDTH    = COORD_WIDTH + 3;
  localparam int SUM_WIDTH     = COORD_WIDTH + 4;

  localparam int FRONT_STAGES  = 4;
  localparam int BACK_STAGES   = 2;
  localparam int PIPE_DEPTH    = FRONT_STAGES + QUO_WIDTH + BACK_STAGES;

  localparam logic [QUO_WIDTH-1:0] TERM_CAP = {1'b1, {(QUO_WIDTH-1){1'b0}}};
  localparam logic signed [SUM_WIDTH-1:0] SUM_MAX =
    SUM_WIDTH'($signed({1'b0, {(COORD_WIDTH-1){1'b1}}}));
  localparam logic signed [SUM_WIDTH-1:0] SUM_MIN =
    SUM_WIDTH'($signed({1'b1, {(COORD_WIDTH-1){1'b0}}}));

  typedef enum logic [CFG_IDX_WIDTH-1:0] {
    CFG_LENS_A_POS,
    CFG_LENS_B_POS,
    CFG_LENS_C_POS,
    CFG_LENS_A_MASS,
    CFG_LENS_B_MASS,
    CFG_LENS_C_MASS
  } cfg_idx_t;

  typedef logic signed [COORD_WIDTH-1:0] coord_t;
  typedef logic [MASS_WIDTH-1:0] mass_t;
  typedef logic signed [TERM_WIDTH-1:0] term_t;

  typedef struct packed {
    coord_t x;
    coord_t y;
  } point_t;

  typedef struct packed {
    coord_t x;
    coord_t y;
    mass_t  m;
  } lens_t;

  typedef struct packed {
    logic                 skip;
    logic                 neg;
    logic                 ovf;
    logic [DEN_WIDTH-1:0] den;
    logic [DEN_WIDTH-1:0] rem;
    logic [QUO_WIDTH-1:0] low;
    logic [QUO_WIDTH-1:0] quo;
  } div_t;

  function automatic div_t div_init(logic [NUM_WIDTH-1:0] num, logic [DEN_WIDTH-1:0] den,
                                    logic neg, logic skip);
    div_t d;
    logic [HEAD_WIDTH-1:0] head;
    head   = num[NUM_WIDTH-1:QUO_WIDTH];
    d.skip = skip;
    d.neg  = neg;
    d.ovf  = CMP_WIDTH'(head) >= CMP_WIDTH'(den);
    d.den  = den;
    d.rem  = DEN_WIDTH'(head);
    d.low  = num[QUO_WIDTH-1:0];
    d.quo  = '0;
    return d;
  endfunction

  function automatic term_t lens_term(div_t d);
    logic [QUO_WIDTH-1:0] mag;
    term_t t;
    mag = (d.ovf || (d.quo > TERM_CAP)) ? TERM_CAP : d.quo;
    t   = $signed(TERM_WIDTH'(mag));
    if (d.skip) begin
      t = '0;
    end else if (d.neg) begin
      t = -t;
    end
    return t;
  endfunction

  function automatic coord_t saturate(logic signed [SUM_WIDTH-1:0] v);
    coord_t r;
    if (v > SUM_MAX) begin
      r = COORD_WIDTH'(SUM_MAX);
    end else if (v < SUM_MIN) begin
      r = COORD_WIDTH'(SUM_MIN);
    end else begin
      r = COORD_WIDTH'(v);
    end
    return r;
  endfunction

endpackage

FILE: src/tlem_ifs.sv
`timescale 1ns / 1ps
interface tlem_in_if;
  logic                valid;
  logic                ready;
  tlem_pkg::coord_t    image_x;
  tlem_pkg::coord_t    image_y;
  modport source (output valid, image_x, image_y, input ready);
  modport sink (input valid, image_x, image_y, output ready);
endinterface

interface tlem_out_if;
  logic                valid;
  logic                ready;
  tlem_pkg::coord_t    source_x;
  tlem_pkg::coord_t    source_y;
  logic                singular;
  modport source (output valid, source_x, source_y, singular, input ready);
  modport sink (input valid, source_x, source_y, singular, output ready);
endinterface

interface tlem_cfg_if;
  logic                                 valid;
  logic                                 ready;
  logic [tlem_pkg::CFG_IDX_WIDTH-1:0]   index;
  logic [tlem_pkg::POS_WIDTH-1:0]       data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

FILE: src/tlem_cfg_regs.sv
`timescale 1ns / 1ps
module tlem_cfg_regs (
  input  logic            clk,
  input  logic            rst_n,
  tlem_cfg_if.sink        cfg,
  output tlem_pkg::lens_t lens_o [tlem_pkg::NUM_LENSES]
);

  logic [tlem_pkg::POS_WIDTH-1:0] pos_r  [tlem_pkg::NUM_LENSES];
  tlem_pkg::mass_t                mass_r [tlem_pkg::NUM_LENSES];

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < tlem_pkg::NUM_LENSES; k++) begin
        pos_r[k]  <= '0;
        mass_r[k] <= '0;
      end
    end else if (cfg.valid && cfg.ready) begin
      unique case (tlem_pkg::cfg_idx_t'(cfg.index))
        tlem_pkg::CFG_LENS_A_POS:  pos_r[0]  <= cfg.data;
        tlem_pkg::CFG_LENS_B_POS:  pos_r[1]  <= cfg.data;
        tlem_pkg::CFG_LENS_C_POS:  pos_r[2]  <= cfg.data;
        tlem_pkg::CFG_LENS_A_MASS: mass_r[0] <= cfg.data[tlem_pkg::MASS_WIDTH-1:0];
        tlem_pkg::CFG_LENS_B_MASS: mass_r[1] <= cfg.data[tlem_pkg::MASS_WIDTH-1:0];
        tlem_pkg::CFG_LENS_C_MASS: mass_r[2] <= cfg.data[tlem_pkg::MASS_WIDTH-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    for (int k = 0; k < tlem_pkg::NUM_LENSES; k++) begin
      lens_o[k].x = tlem_pkg::COORD_WIDTH'($signed(pos_r[k][tlem_pkg::LANE_WIDTH-1:0]));
      lens_o[k].y = tlem_pkg::COORD_WIDTH'(
        $signed(pos_r[k][tlem_pkg::HALF_WIDTH +: tlem_pkg::LANE_WIDTH]));
      lens_o[k].m = mass_r[k];
    end
  end

endmodule

FILE: src/tlem_lens_front.sv
`timescale 1ns / 1ps
module tlem_lens_front (
  input  logic                                clk,
  input  logic [tlem_pkg::FRONT_STAGES-1:0]   ld,
  input  tlem_pkg::point_t                    img,
  input  tlem_pkg::lens_t                     lens,
  output tlem_pkg::div_t                      div_x,
  output tlem_pkg::div_t                      div_y
);

  logic signed [tlem_pkg::OFF_WIDTH-1:0] offx, offy;
  logic [tlem_pkg::MAG_WIDTH-1:0]        magx_r, magy_r;
  logic                                  negx_r, negy_r;
  logic [tlem_pkg::SQ_WIDTH-1:0]         sqx_r, sqy_r;
  logic [tlem_pkg::PROD_WIDTH-1:0]       px_r, py_r;
  logic                                  negx1_r, negy1_r;
  logic [tlem_pkg::DEN_RAW_WIDTH-1:0]    den_raw;
  logic [tlem_pkg::DEN_WIDTH-1:0]        den_r, den_nxt;
  logic [tlem_pkg::NUM_WIDTH-1:0]        numx_r, numy_r, numx_nxt, numy_nxt;
  logic                                  zero_r, negx2_r, negy2_r;
  tlem_pkg::div_t                        div_x_r, div_y_r;

  assign offx = tlem_pkg::OFF_WIDTH'(img.x) - tlem_pkg::OFF_WIDTH'(lens.x);
  assign offy = tlem_pkg::OFF_WIDTH'(img.y) - tlem_pkg::OFF_WIDTH'(lens.y);

  always_ff @(posedge clk) begin
    if (ld[0]) begin
      negx_r <= offx[tlem_pkg::OFF_WIDTH-1];
      negy_r <= offy[tlem_pkg::OFF_WIDTH-1];
      magx_r <= offx[tlem_pkg::OFF_WIDTH-1] ? tlem_pkg::MAG_WIDTH'(-offx)
                                            : tlem_pkg::MAG_WIDTH'(offx);
      magy_r <= offy[tlem_pkg::OFF_WIDTH-1] ? tlem_pkg::MAG_WIDTH'(-offy)
                                            : tlem_pkg::MAG_WIDTH'(offy);
    end
  end

  always_ff @(posedge clk) begin
    if (ld[1]) begin
      sqx_r   <= tlem_pkg::SQ_WIDTH'(magx_r) * tlem_pkg::SQ_WIDTH'(magx_r);
      sqy_r   <= tlem_pkg::SQ_WIDTH'(magy_r) * tlem_pkg::SQ_WIDTH'(magy_r);
      px_r    <= tlem_pkg::PROD_WIDTH'(lens.m) * tlem_pkg::PROD_WIDTH'(magx_r);
      py_r    <= tlem_pkg::PROD_WIDTH'(lens.m) * tlem_pkg::PROD_WIDTH'(magy_r);
      negx1_r <= negx_r;
      negy1_r <= negy_r;
    end
  end

  always_comb begin
    den_raw  = tlem_pkg::DEN_RAW_WIDTH'(sqx_r) + tlem_pkg::DEN_RAW_WIDTH'(sqy_r);
    den_nxt  = tlem_pkg::DEN_WIDTH'(den_raw) << tlem_pkg::DEN_SHIFT;
    numx_nxt = tlem_pkg::NUM_WIDTH'(px_r) << tlem_pkg::NUM_SHIFT;
    numy_nxt = tlem_pkg::NUM_WIDTH'(py_r) << tlem_pkg::NUM_SHIFT;
  end

  always_ff @(posedge clk) begin
    if (ld[2]) begin
      den_r   <= den_nxt;
      zero_r  <= (sqx_r == '0) && (sqy_r == '0);
      numx_r  <= numx_nxt;
      numy_r  <= numy_nxt;
      negx2_r <= negx1_r;
      negy2_r <= negy1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (ld[3]) begin
      div_x_r <= tlem_pkg::div_init(numx_r, den_r, negx2_r, zero_r);
      div_y_r <= tlem_pkg::div_init(numy_r, den_r, negy2_r, zero_r);
    end
  end

  assign div_x = div_x_r;
  assign div_y = div_y_r;

endmodule

FILE: src/tlem_div_step.sv
`timescale 1ns / 1ps
module tlem_div_step (
  input  logic           clk,
  input  logic           ld,
  input  tlem_pkg::div_t div_i,
  output tlem_pkg::div_t div_o
);

  logic [tlem_pkg::DEN_WIDTH:0] trial, diff;
  logic                         fits;
  tlem_pkg::div_t               div_r, div_nxt;

  always_comb begin
    trial   = {div_i.rem, div_i.low[tlem_pkg::QUO_WIDTH-1]};
    diff    = trial - {1'b0, div_i.den};
    fits    = trial >= {1'b0, div_i.den};
    div_nxt = div_i;
    div_nxt.low = div_i.low << 1;
    div_nxt.quo = {div_i.quo[tlem_pkg::QUO_WIDTH-2:0], fits};
    div_nxt.rem = fits ? diff[tlem_pkg::DEN_WIDTH-1:0] : trial[tlem_pkg::DEN_WIDTH-1:0];
  end

  always_ff @(posedge clk) begin
    if (ld) begin
      div_r <= div_nxt;
    end
  end

  assign div_o = div_r;

endmodule

FILE: src/tlem_combine.sv
`timescale 1ns / 1ps
module tlem_combine (
  input  logic                                 clk,
  input  logic [tlem_pkg::BACK_STAGES-1:0]     ld,
  input  tlem_pkg::point_t                     img,
  input  tlem_pkg::div_t                       qx [tlem_pkg::NUM_LENSES],
  input  tlem_pkg::div_t                       qy [tlem_pkg::NUM_LENSES],
  output tlem_pkg::coord_t                     source_x,
  output tlem_pkg::coord_t                     source_y,
  output logic                                 singular
);

  tlem_pkg::term_t                       tx_r [tlem_pkg::NUM_LENSES];
  tlem_pkg::term_t                       ty_r [tlem_pkg::NUM_LENSES];
  tlem_pkg::point_t                      img_r;
  logic                                  sing_r, sing_out_r;
  logic signed [tlem_pkg::SUM_WIDTH-1:0] sumx, sumy;
  tlem_pkg::coord_t                      srcx_r, srcy_r;

  always_ff @(posedge clk) begin
    if (ld[0]) begin
      for (int k = 0; k < tlem_pkg::NUM_LENSES; k++) begin
        tx_r[k] <= tlem_pkg::lens_term(qx[k]);
        ty_r[k] <= tlem_pkg::lens_term(qy[k]);
      end
      img_r  <= img;
      sing_r <= qx[0].skip || qx[1].skip || qx[2].skip;
    end
  end

  always_comb begin
    sumx = tlem_pkg::SUM_WIDTH'(img_r.x);
    sumy = tlem_pkg::SUM_WIDTH'(img_r.y);
    for (int k = 0; k < tlem_pkg::NUM_LENSES; k++) begin
      sumx = sumx - tlem_pkg::SUM_WIDTH'(tx_r[k]);
      sumy = sumy - tlem_pkg::SUM_WIDTH'(ty_r[k]);
    end
  end

  always_ff @(posedge clk) begin
    if (ld[1]) begin
      srcx_r     <= tlem_pkg::saturate(sumx);
      srcy_r     <= tlem_pkg::saturate(sumy);
      sing_out_r <= sing_r;
    end
  end

  assign source_x = srcx_r;
  assign source_y = srcy_r;
  assign singular = sing_out_r;

endmodule

FILE: src/triple_lens_equation_map.sv
`timescale 1ns / 1ps
// channel   port     direction  payload
// --------  -------  ---------  --------------------------------------
// input     in_ch    sink       image_x, image_y (Q8.24)
// result    out_ch   source     source_x, source_y (Q8.24), singular
// config    cfg_ch   sink       index, data (lens positions and masses)
//
// One point per cycle unless out_ch stalls; 4 front stages (offset, square and
// mass product, denominator, overflow check), 34 quotient-bit divider stages,
// 2 back stages (clamp, sum and saturate into the output register).
// Reset clears all stage valid bits and the lens registers.
// A stalled result holds; stages behind it keep filling empty slots, so the
// input stalls only once every stage is occupied.
module triple_lens_equation_map (
  input  logic       clk,
  input  logic       rst_n,
  tlem_in_if.sink    in_ch,
  tlem_out_if.source out_ch,
  tlem_cfg_if.sink   cfg_ch
);

  localparam int DivStages = tlem_pkg::QUO_WIDTH;
  localparam int ImgStages = tlem_pkg::FRONT_STAGES + tlem_pkg::QUO_WIDTH;

  logic [tlem_pkg::PIPE_DEPTH-1:0] ld, vld_r, vld_nxt;
  tlem_pkg::lens_t                 lens [tlem_pkg::NUM_LENSES];
  tlem_pkg::point_t                in_pt;
  tlem_pkg::point_t                img_r [ImgStages];
  tlem_pkg::div_t                  dx_c [tlem_pkg::NUM_LENSES][DivStages+1];
  tlem_pkg::div_t                  dy_c [tlem_pkg::NUM_LENSES][DivStages+1];
  tlem_pkg::div_t                  qx [tlem_pkg::NUM_LENSES];
  tlem_pkg::div_t                  qy [tlem_pkg::NUM_LENSES];

  always_comb begin
    ld[tlem_pkg::PIPE_DEPTH-1] = !vld_r[tlem_pkg::PIPE_DEPTH-1] || out_ch.ready;
    for (int i = tlem_pkg::PIPE_DEPTH - 2; i >= 0; i--) begin
      ld[i] = !vld_r[i] || ld[i+1];
    end
  end

  always_comb begin
    vld_nxt[0] = ld[0] ? in_ch.valid : vld_r[0];
    for (int i = 1; i < tlem_pkg::PIPE_DEPTH; i++) begin
      vld_nxt[i] = ld[i] ? vld_r[i-1] : vld_r[i];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  assign in_ch.ready  = ld[0];
  assign out_ch.valid = vld_r[tlem_pkg::PIPE_DEPTH-1];
  assign in_pt.x      = in_ch.image_x;
  assign in_pt.y      = in_ch.image_y;

  always_ff @(posedge clk) begin
    if (ld[0]) begin
      img_r[0] <= in_pt;
    end
    for (int i = 1; i < ImgStages; i++) begin
      if (ld[i]) begin
        img_r[i] <= img_r[i-1];
      end
    end
  end

  tlem_cfg_regs u_cfg (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg    (cfg_ch),
    .lens_o (lens)
  );

  for (genvar k = 0; k < tlem_pkg::NUM_LENSES; k++) begin : g_lens
    tlem_lens_front u_front (
      .clk   (clk),
      .ld    (ld[tlem_pkg::FRONT_STAGES-1:0]),
      .img   (in_pt),
      .lens  (lens[k]),
      .div_x (dx_c[k][0]),
      .div_y (dy_c[k][0])
    );
    for (genvar j = 0; j < DivStages; j++) begin : g_step
      tlem_div_step u_step_x (
        .clk   (clk),
        .ld    (ld[tlem_pkg::FRONT_STAGES+j]),
        .div_i (dx_c[k][j]),
        .div_o (dx_c[k][j+1])
      );
      tlem_div_step u_step_y (
        .clk   (clk),
        .ld    (ld[tlem_pkg::FRONT_STAGES+j]),
        .div_i (dy_c[k][j]),
        .div_o (dy_c[k][j+1])
      );
    end
    assign qx[k] = dx_c[k][DivStages];
    assign qy[k] = dy_c[k][DivStages];
  end

  tlem_combine u_combine (
    .clk      (clk),
    .ld       (ld[tlem_pkg::PIPE_DEPTH-1 -: tlem_pkg::BACK_STAGES]),
    .img      (img_r[ImgStages-1]),
    .qx       (qx),
    .qy       (qy),
    .source_x (out_ch.source_x),
    .source_y (out_ch.source_y),
    .singular (out_ch.singular)
  );

endmodule

FILE: src/tlem_checker.sv
`timescale 1ns / 1ps
module tlem_checker (
  input logic             clk,
  input logic             rst_n,
  input logic             in_ready,
  input logic             out_valid,
  input logic             out_ready,
  input tlem_pkg::coord_t source_x,
  input tlem_pkg::coord_t source_y,
  input logic             singular
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(source_x) && $stable(source_y)
                                && $stable(singular))
    else $error("stalled result changed");

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  a_ready_passes: assert property (@(posedge clk) disable iff (!rst_n)
    out_ready |-> in_ready)
    else $error("input stalled while result side drains");

  a_empty_out_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input stalled with empty output register");

endmodule

bind triple_lens_equation_map tlem_checker u_tlem_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .source_x  (out_ch.source_x),
  .source_y  (out_ch.source_y),
  .singular  (out_ch.singular)
);
